### rtl/core/wifi_join_link_tracker_defines.svh
// ----------------------------------------------------------------------------
// wifi_join_link_tracker_defines.svh
// Assertion macros shared by the join link tracker RTL.
// ----------------------------------------------------------------------------
`ifndef WIFI_JOIN_LINK_TRACKER_DEFINES_SVH
`define WIFI_JOIN_LINK_TRACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define WJLT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wjlt check failed");

// Next-cycle implication, checked out of reset
`define WJLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wjlt check failed");

`endif

### rtl/core/wjlt_pkg.sv
// ----------------------------------------------------------------------------
// wjlt_pkg
// Types, codes and widths shared by the join link tracker modules.
// ----------------------------------------------------------------------------
package wjlt_pkg;

  // Tick timer width and the width used for limit compares
  localparam int TIMER_BITS = 24;
  localparam int LIMIT_W    = 24;
  localparam int CMP_W      = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

  // Join machine phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_JOINING = 2'd1,
    PH_JOINED  = 2'd2,
    PH_FAILED  = 2'd3
  } phase_t;

  // Item kinds
  localparam logic FUNC_POLL  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  // Firmware event kinds
  localparam logic [2:0] EV_LINK   = 3'd0;
  localparam logic [2:0] EV_SUPP   = 3'd1;
  localparam logic [2:0] EV_DISASC = 3'd2;
  localparam logic [2:0] EV_SSID   = 3'd3;

  // Event status words of interest
  localparam logic [31:0] ST_AUTH_OK   = 32'd6;
  localparam logic [31:0] ST_SEC_REJ   = 32'd1;
  localparam logic [31:0] ST_NOT_FOUND = 32'd3;

  // Link flag bits: 0 up, 1 auth, 2 failed
  localparam int FB_UP   = 0;
  localparam int FB_AUTH = 1;
  localparam int FB_FAIL = 2;
  localparam logic [2:0] FL_FAILED_ONLY = 3'b100;

  // Link status codes (two's complement)
  localparam logic [1:0] LS_PENDING = 2'b00;
  localparam logic [1:0] LS_JOINED  = 2'b01;
  localparam logic [1:0] LS_FAILED  = 2'b11;

  // Join error codes
  localparam logic [1:0] JE_NONE      = 2'd0;
  localparam logic [1:0] JE_SEC_REJ   = 2'd1;
  localparam logic [1:0] JE_NOT_FOUND = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_OPEN    = 2'd0;
  localparam logic [1:0] CFG_JOIN_TO = 2'd1;
  localparam logic [1:0] CFG_RETRY   = 2'd2;

  typedef struct packed {
    logic        func;
    logic        on_event_channel;
    logic [2:0]  event_kind;
    logic [31:0] event_status;
    logic        link_flag;
  } item_t;

  typedef struct packed {
    logic                open_network;
    logic [LIMIT_W-1:0]  join_timeout_ticks;
    logic [LIMIT_W-1:0]  retry_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] join_error;
    logic       event_handled;
    logic       stop_join;
    logic       start_join;
    logic [1:0] link_status;
    logic       link_failed;
    logic       link_auth;
    logic       link_up;
    logic [1:0] join_state;
  } result_t;

endpackage

### rtl/core/wjlt_in_stage.sv
// ----------------------------------------------------------------------------
// wjlt_in_stage
// Input register: captures one item per cycle, holds it while downstream stalls.
// ----------------------------------------------------------------------------
module wjlt_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  wjlt_pkg::item_t in_item,
  output logic            in_ready,
  input  logic            advance,
  output logic            stage_valid,
  output wjlt_pkg::item_t stage_item
);
  import wjlt_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Stage frees up when empty or when its item moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

### rtl/core/wjlt_step.sv
// ----------------------------------------------------------------------------
// wjlt_step
// Join machine, link flags and tick timer: one item's update and its result.
// ----------------------------------------------------------------------------
module wjlt_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  wjlt_pkg::item_t   item,
  input  wjlt_pkg::cfg_t    cfg,
  output wjlt_pkg::result_t res
);
  import wjlt_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            flags_r, flags_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;

  logic [TIMER_BITS-1:0] timer_inc;
  logic                  flags_ok;
  logic                  join_to_hit;
  logic                  retry_hit;
  logic [2:0]            ev_flags;
  logic                  start_c, stop_c, handled_c;
  logic [1:0]            err_c;

  // Saturating tick and limit compares
  assign timer_inc   = (&timer_r) ? timer_r : timer_r + 1'b1;
  assign join_to_hit = CMP_W'(timer_inc) >= CMP_W'(cfg.join_timeout_ticks);
  assign retry_hit   = CMP_W'(timer_inc) >= CMP_W'(cfg.retry_delay_ticks);
  assign flags_ok    = flags_r[FB_UP] && flags_r[FB_AUTH];

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    timer_nxt = timer_r;
    start_c   = 1'b0;
    stop_c    = 1'b0;
    handled_c = 1'b0;
    err_c     = JE_NONE;
    ev_flags  = flags_r;

    if (item.func == FUNC_POLL) begin
      timer_nxt = timer_inc;
      unique case (phase_r)
        PH_IDLE: begin
          flags_nxt = '0;
          timer_nxt = '0;
          phase_nxt = PH_JOINING;
          start_c   = 1'b1;
        end
        PH_JOINING: begin
          if (flags_ok) begin
            phase_nxt = PH_JOINED;
          end else if (flags_r == FL_FAILED_ONLY || join_to_hit) begin
            timer_nxt = '0;
            stop_c    = 1'b1;
            phase_nxt = PH_FAILED;
          end
        end
        PH_JOINED: begin
          timer_nxt = '0;
          if (!flags_ok) begin
            stop_c    = 1'b1;
            phase_nxt = PH_FAILED;
          end
        end
        PH_FAILED: begin
          if (retry_hit) begin
            timer_nxt = '0;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else if (item.on_event_channel) begin
      // Open network forces auth before the event applies
      ev_flags[FB_AUTH] = flags_r[FB_AUTH] | cfg.open_network;
      handled_c = 1'b1;
      if (item.event_kind == EV_LINK && item.event_status == '0) begin
        ev_flags[FB_UP] = item.link_flag;
      end else if (item.event_kind == EV_SUPP) begin
        ev_flags[FB_AUTH] = (item.event_status == ST_AUTH_OK);
      end else if (item.event_kind == EV_DISASC) begin
        ev_flags = FL_FAILED_ONLY;
      end else if (item.event_kind == EV_SSID) begin
        if (item.event_status == ST_SEC_REJ) begin
          err_c = JE_SEC_REJ;
        end else if (item.event_status == ST_NOT_FOUND) begin
          err_c = JE_NOT_FOUND;
        end
      end else begin
        handled_c = 1'b0;
      end
      flags_nxt = ev_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flags_r <= '0;
      timer_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      timer_r <= timer_nxt;
    end
  end

  // Result reflects state after this item
  always_comb begin
    res.join_state    = phase_nxt;
    res.link_up       = flags_nxt[FB_UP];
    res.link_auth     = flags_nxt[FB_AUTH];
    res.link_failed   = flags_nxt[FB_FAIL];
    if (flags_nxt[FB_UP] && flags_nxt[FB_AUTH]) begin
      res.link_status = LS_JOINED;
    end else if (flags_nxt == FL_FAILED_ONLY) begin
      res.link_status = LS_FAILED;
    end else begin
      res.link_status = LS_PENDING;
    end
    res.start_join    = start_c;
    res.stop_join     = stop_c;
    res.event_handled = handled_c;
    res.join_error    = err_c;
  end

endmodule

### rtl/core/wifi_join_link_tracker.sv
// ----------------------------------------------------------------------------
// wifi_join_link_tracker
// Network join supervisor: link flags, join machine and tick timer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries poll ticks and firmware events (in_tuser[0] = 0 poll,
//   1 event). Each accepted item gives exactly one result item on the out_
//   stream, in order: join phase, link flags, link status, start/stop pulses,
//   event handled flag and set ssid error.
//   Configuration (open network, join timeout, retry delay) is written through
//   cfg_we/cfg_index/cfg_data while no item is in flight; index 3 is ignored.
//   An accepted item passes the input register, then flag/timer/phase update
//   and compare logic, into the result register.
//   Throughput: one item per cycle while results are taken; the join machine
//   updates its state as each item moves on, so items may follow back to back.
//   Reset (rst_n low, synchronous): phase idle, flags and timer zero, open
//   network 0, both tick limits 10000, both stages empty.
//   When the receiver stalls the result is held; the input register still
//   takes one more item, after which in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
`include "wifi_join_link_tracker_defines.svh"

module wifi_join_link_tracker (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: event_kind[2:0], event_status[34:3], link_flag[35], zero[39:36]
  input  logic [39:0] in_tdata,
  // in_tuser: func[0], on_event_channel[1]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: join_state[1:0], link_up[2], link_auth[3], link_failed[4],
  //   link_status[6:5], start_join[7], stop_join[8], event_handled[9],
  //   join_error[11:10], zero[15:12]
  output logic [15:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import wjlt_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    fire;
  result_t res;
  result_t out_r;
  logic    out_valid_r, out_valid_nxt;
  cfg_t    cfg_r;

  // Unpack input payload
  assign in_item.func             = in_tuser[0];
  assign in_item.on_event_channel = in_tuser[1];
  assign in_item.event_kind       = in_tdata[2:0];
  assign in_item.event_status     = in_tdata[34:3];
  assign in_item.link_flag        = in_tdata[35];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_network       <= 1'b0;
      cfg_r.join_timeout_ticks <= LIMIT_W'(10000);
      cfg_r.retry_delay_ticks  <= LIMIT_W'(10000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPEN:    cfg_r.open_network       <= cfg_data[0];
        CFG_JOIN_TO: cfg_r.join_timeout_ticks <= cfg_data;
        CFG_RETRY:   cfg_r.retry_delay_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Result register frees up when empty or taken
  assign advance = !out_valid_r || out_tready;
  assign fire    = stage_valid && advance;

  wjlt_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_item     (in_item),
    .in_ready    (in_tready),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  wjlt_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (stage_item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

  // Checks
  `WJLT_ASSERT_IMPL(a_start_to_joining,
    out_valid_r && out_r.start_join, out_r.join_state == PH_JOINING)
  `WJLT_ASSERT_IMPL(a_stop_to_failed,
    out_valid_r && out_r.stop_join, out_r.join_state == PH_FAILED)
  `WJLT_ASSERT_IMPL(a_joined_flags,
    out_valid_r && out_r.link_status == LS_JOINED, out_r.link_up && out_r.link_auth)
  `WJLT_ASSERT_NEXT(a_full_blocks_input,
    stage_valid && !advance && !fire, stage_valid)

endmodule

### verif/wjlt_link_checker.sv
// ----------------------------------------------------------------------------
// wjlt_link_checker
// Watches the item, result and register ports of the join link tracker,
// predicts each result from its own copy of the link flags, join phase, tick
// timer and registers, and compares every delivered result field by field.
// ----------------------------------------------------------------------------
module wjlt_link_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results_checked,
  output int          starts_seen,
  output int          stops_seen,
  output int          joins_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import wjlt_pkg::*;

  // Shadow state of the block
  phase_t                phase;
  logic [2:0]            flags;
  logic [TIMER_BITS-1:0] ticks;
  cfg_t                  regs;
  result_t               expected_results[$];

  // Joined when up and auth are both set, failed when only the fail bit is
  function automatic logic [1:0] link_code(input logic [2:0] f);
    if (f[FB_UP] && f[FB_AUTH]) return LS_JOINED;
    if (f == FL_FAILED_ONLY) return LS_FAILED;
    return LS_PENDING;
  endfunction

  // Apply one item to the shadow state and return the result it causes
  function automatic result_t track_item(input item_t it);
    result_t    r;
    logic [2:0] f;
    r = '0;
    if (it.func == FUNC_POLL) begin
      if (ticks != '1) ticks = ticks + 1'b1;
      case (phase)
        PH_IDLE: begin
          flags = '0;
          ticks = '0;
          phase = PH_JOINING;
          r.start_join = 1'b1;
        end
        PH_JOINING: begin
          if (link_code(flags) == LS_JOINED) begin
            phase = PH_JOINED;
          end else if (link_code(flags) == LS_FAILED ||
                       ticks >= regs.join_timeout_ticks) begin
            ticks = '0;
            r.stop_join = 1'b1;
            phase = PH_FAILED;
          end
        end
        PH_JOINED: begin
          ticks = '0;
          if (link_code(flags) != LS_JOINED) begin
            r.stop_join = 1'b1;
            phase = PH_FAILED;
          end
        end
        default: begin
          if (ticks >= regs.retry_delay_ticks) begin
            ticks = '0;
            phase = PH_IDLE;
          end
        end
      endcase
    end else if (it.on_event_channel) begin
      // open network forces auth before the event acts
      f = flags;
      if (regs.open_network) f[FB_AUTH] = 1'b1;
      r.event_handled = 1'b1;
      if (it.event_kind == EV_LINK && it.event_status == 32'd0) begin
        f[FB_UP] = it.link_flag;
      end else if (it.event_kind == EV_SUPP) begin
        f[FB_AUTH] = (it.event_status == ST_AUTH_OK);
      end else if (it.event_kind == EV_DISASC) begin
        f = FL_FAILED_ONLY;
      end else if (it.event_kind == EV_SSID) begin
        if (it.event_status == ST_SEC_REJ) r.join_error = JE_SEC_REJ;
        else if (it.event_status == ST_NOT_FOUND) r.join_error = JE_NOT_FOUND;
      end else begin
        r.event_handled = 1'b0;
      end
      flags = f;
    end
    r.join_state  = phase;
    r.link_up     = flags[FB_UP];
    r.link_auth   = flags[FB_AUTH];
    r.link_failed = flags[FB_FAIL];
    r.link_status = link_code(flags);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Register writes, item prediction and result comparison
  always @(posedge clk) begin : watch
    item_t   it;
    result_t want;
    result_t got;
    if (!rst_n) begin
      phase = PH_IDLE;
      flags = '0;
      ticks = '0;
      regs.open_network       = 1'b0;
      regs.join_timeout_ticks = 24'd10000;
      regs.retry_delay_ticks  = 24'd10000;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OPEN:    regs.open_network       = cfg_data[0];
          CFG_JOIN_TO: regs.join_timeout_ticks = cfg_data;
          CFG_RETRY:   regs.retry_delay_ticks  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        it.func             = in_tuser[0];
        it.on_event_channel = in_tuser[1];
        it.event_kind       = in_tdata[2:0];
        it.event_status     = in_tdata[34:3];
        it.link_flag        = in_tdata[35];
        want = track_item(it);
        expected_results.push_back(want);
        if (want.start_join) starts_seen++;
        if (want.stop_join) stops_seen++;
        if (it.func == FUNC_POLL && want.join_state == PH_JOINED) joins_seen++;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[11:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result %h arrived with none expected", $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("join_state", want.join_state, got.join_state);
          check_field("link_up", want.link_up, got.link_up);
          check_field("link_auth", want.link_auth, got.link_auth);
          check_field("link_failed", want.link_failed, got.link_failed);
          check_field("link_status", want.link_status, got.link_status);
          check_field("start_join", want.start_join, got.start_join);
          check_field("stop_join", want.stop_join, got.stop_join);
          check_field("event_handled", want.event_handled, got.event_handled);
          check_field("join_error", want.join_error, got.join_error);
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

### verif/wifi_join_link_tracker_test.sv
// ----------------------------------------------------------------------------
// wifi_join_link_tracker_test
// Drives poll ticks and firmware events into the join link tracker under
// random source gaps and sink stalls, across several register settings, and
// reports the verdict of the checker that watches its ports.
// ----------------------------------------------------------------------------
module wifi_join_link_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wjlt_pkg::*;

  localparam int         STALL_LIMIT = 600;
  localparam logic [2:0] EV_OTHER_LO = 3'd4;
  localparam logic [2:0] EV_OTHER_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_OPEN;
  logic [23:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  int          results_checked;
  int          starts_seen;
  int          stops_seen;
  int          joins_seen;
  bit          tx_burst;
  bit          rx_burst;
  int unsigned rx_hold;
  int          idle_cycles;
  int          settings_used;
  int          sent;

  wifi_join_link_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wjlt_link_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .starts_seen     (starts_seen),
    .stops_seen      (stops_seen),
    .joins_seen      (joins_seen)
  );

  always #2 clk = ~clk;

  // Cycles to wait before the next item; none while in a burst
  function automatic int unsigned pace_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // Result sink: a random stall after each result, with no-stall stretches now and then
  always @(posedge clk) begin : rx_pace
    int unsigned n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      n = pace_draw(rx_burst);
      rx_hold    <= n;
      out_tready <= (n == 0);
    end else if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Poll tick; the unused fields still carry random bits
  function automatic item_t poll_item();
    item_t it;
    it.func             = FUNC_POLL;
    it.on_event_channel = 1'($urandom_range(0, 1));
    it.event_kind       = 3'($urandom_range(0, 7));
    it.event_status     = $urandom;
    it.link_flag        = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t event_item(input logic chan, input logic [2:0] kind,
                                       input logic [31:0] status, input logic flag);
    item_t it;
    it.func             = FUNC_EVENT;
    it.on_event_channel = chan;
    it.event_kind       = kind;
    it.event_status     = status;
    it.link_flag        = flag;
    return it;
  endfunction

  // Mostly events on the event channel with the status words that matter
  function automatic item_t random_item();
    int unsigned   pick;
    logic [31:0]   st;
    logic [2:0]    kind;
    pick = $urandom_range(0, 99);
    if (pick < 35) return poll_item();
    case ($urandom_range(0, 5))
      0:       st = 32'd0;
      1:       st = ST_SEC_REJ;
      2:       st = ST_NOT_FOUND;
      3:       st = ST_AUTH_OK;
      4:       st = 32'hFFFF_FFFF;
      default: st = $urandom;
    endcase
    kind = (pick < 90) ? 3'($urandom_range(EV_LINK, EV_SSID))
                       : 3'($urandom_range(EV_OTHER_LO, EV_OTHER_HI));
    return event_item($urandom_range(0, 9) != 0, kind, st, 1'($urandom_range(0, 1)));
  endfunction

  // Present one item after a random gap and hold it until taken
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = pace_draw(tx_burst);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'b0, it.link_flag, it.event_status, it.event_kind};
    in_tuser  <= {it.on_event_channel, it.func};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!(it.func == FUNC_EVENT && !it.on_event_channel)) sent++;
  endtask

  // Let every result drain, then write all three registers
  task automatic write_settings(input logic open, input logic [23:0] join_to,
                                input logic [23:0] retry);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OPEN;
    cfg_data  <= {23'd0, open};
    @(posedge clk);
    cfg_index <= CFG_JOIN_TO;
    cfg_data  <= join_to;
    @(posedge clk);
    cfg_index <= CFG_RETRY;
    cfg_data  <= retry;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // A well-formed join: a few polls, link up, auth ok, polls, maybe a drop
  task automatic join_episode();
    int unsigned polls;
    repeat ($urandom_range(0, 2)) send_item(poll_item());
    send_item(event_item(1'b1, EV_LINK, 32'd0, 1'b1));
    send_item(event_item(1'b1, EV_SUPP, ST_AUTH_OK, 1'($urandom_range(0, 1))));
    polls = $urandom_range(1, 4);
    repeat (polls) send_item(poll_item());
    case ($urandom_range(0, 3))
      0:       send_item(event_item(1'b1, EV_LINK, 32'd0, 1'b0));
      1:       send_item(event_item(1'b1, EV_DISASC, $urandom, 1'($urandom_range(0, 1))));
      2:       send_item(event_item(1'b1, EV_SUPP, $urandom, 1'($urandom_range(0, 1))));
      default: ;
    endcase
  endtask

  task automatic random_phase(input int target);
    int first;
    first = sent;
    while (sent - first < target) begin
      if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
      if ($urandom_range(0, 9) < 4) join_episode();
      else send_item(random_item());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, every event kind and the status words of note
    send_item(poll_item());                                       // idle -> joining
    send_item(event_item(1'b0, EV_LINK, 32'd0, 1'b1));            // off channel
    send_item(event_item(1'b1, EV_LINK, 32'd0, 1'b1));            // link up
    send_item(event_item(1'b1, EV_LINK, 32'hFFFF_FFFF, 1'b0));    // bad status
    send_item(event_item(1'b1, EV_SUPP, 32'd5, 1'b0));            // auth fail
    send_item(event_item(1'b1, EV_SUPP, ST_AUTH_OK, 1'b1));       // auth ok
    send_item(event_item(1'b1, EV_SSID, ST_SEC_REJ, 1'b0));
    send_item(event_item(1'b1, EV_SSID, ST_NOT_FOUND, 1'b1));
    send_item(event_item(1'b1, EV_SSID, 32'hFFFF_FFFF, 1'b0));
    send_item(event_item(1'b1, EV_OTHER_LO, 32'd0, 1'b0));
    send_item(event_item(1'b1, EV_OTHER_HI, 32'hFFFF_FFFF, 1'b1));
    send_item(poll_item());                                       // -> joined
    send_item(poll_item());                                       // stays joined
    send_item(event_item(1'b1, EV_LINK, 32'd0, 1'b0));            // link down
    send_item(poll_item());                                       // -> failed, stop
    send_item(poll_item());                                       // retry not due
    send_item(event_item(1'b1, EV_DISASC, 32'd0, 1'b1));          // failed only

    // Zero limits on an open network: immediate timeouts and retries
    write_settings(1'b1, 24'd0, 24'd0);
    send_item(poll_item());                                       // failed -> idle
    send_item(poll_item());                                       // idle -> joining
    send_item(poll_item());                                       // join timeout
    send_item(poll_item());
    send_item(poll_item());
    send_item(event_item(1'b1, EV_OTHER_LO, 32'd7, 1'b0));        // forced auth kept
    send_item(event_item(1'b1, EV_DISASC, 32'hFFFF_FFFF, 1'b0));
    send_item(poll_item());                                       // failed status

    write_settings(1'b0, 24'd5, 24'd3);
    random_phase(150);
    write_settings(1'b1, 24'd2, 24'd1);
    random_phase(150);
    write_settings(1'b0, 24'hFF_FFFF, 24'hFF_FFFF);
    random_phase(80);
    write_settings(1'b1, 24'd12, 24'd8);
    random_phase(150);
    write_settings(1'b0, 24'd1, 24'd0);
    random_phase(150);

    // Drain and settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d results over %0d register settings", results_checked,
             settings_used + 1);
    $display("Join starts %0d, stop pulses %0d, polls ending joined %0d",
             starts_seen, stops_seen, joins_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/wjlt_pkg.sv
rtl/core/wjlt_in_stage.sv
rtl/core/wjlt_step.sv
rtl/core/wifi_join_link_tracker.sv
verif/wjlt_link_checker.sv
verif/wifi_join_link_tracker_test.sv
